FILE: src/irdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR ring direction finder package
// Shared constants and tables.
// ----------------------------------------------------------------------------
package irdf_pkg;

  localparam int unsigned TableSteps  = 24;
  localparam int unsigned CordicSteps = 16;
  localparam logic [8:0]  NoSignal    = 9'd400;
  localparam logic [4:0]  TopReset    = 5'd6;

  // Cosine of i*15 degrees, Q1.14.
  function automatic logic signed [15:0] cos_q14(input logic [4:0] idx);
    logic signed [15:0] v;
    unique case (idx)
      5'd0:  v = 16'sd16384;
      5'd1:  v = 16'sd15826;
      5'd2:  v = 16'sd14189;
      5'd3:  v = 16'sd11585;
      5'd4:  v = 16'sd8192;
      5'd5:  v = 16'sd4240;
      5'd6:  v = 16'sd0;
      5'd7:  v = -16'sd4240;
      5'd8:  v = -16'sd8192;
      5'd9:  v = -16'sd11585;
      5'd10: v = -16'sd14189;
      5'd11: v = -16'sd15826;
      5'd12: v = -16'sd16384;
      5'd13: v = -16'sd15826;
      5'd14: v = -16'sd14189;
      5'd15: v = -16'sd11585;
      5'd16: v = -16'sd8192;
      5'd17: v = -16'sd4240;
      5'd18: v = 16'sd0;
      5'd19: v = 16'sd4240;
      5'd20: v = 16'sd8192;
      5'd21: v = 16'sd11585;
      5'd22: v = 16'sd14189;
      5'd23: v = 16'sd15826;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] sin_idx(input logic [4:0] idx);
    logic [5:0] s;
    s = {1'b0, idx} + 6'd18;
    if (s >= 6'd24) begin
      s = s - 6'd24;
    end
    return s[4:0];
  endfunction

  // Arctangent of 2^-i in units of 2^-16 degree.
  function automatic logic [21:0] atan_deg16(input logic [3:0] i);
    logic [21:0] v;
    unique case (i)
      4'd0:  v = 22'd2949120;
      4'd1:  v = 22'd1740967;
      4'd2:  v = 22'd919879;
      4'd3:  v = 22'd466945;
      4'd4:  v = 22'd234379;
      4'd5:  v = 22'd117304;
      4'd6:  v = 22'd58666;
      4'd7:  v = 22'd29335;
      4'd8:  v = 22'd14668;
      4'd9:  v = 22'd7334;
      4'd10: v = 22'd3667;
      4'd11: v = 22'd1833;
      4'd12: v = 22'd917;
      4'd13: v = 22'd458;
      4'd14: v = 22'd229;
      default: v = 22'd115;
    endcase
    return v;
  endfunction

endpackage

FILE: src/irdf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR ring direction finder front end
// Count hits per sensor, compute percentages at window close.
// ----------------------------------------------------------------------------
module irdf_front #(
  parameter int unsigned SENSORS     = 24,
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SENSORS-1:0]     sensor_levels_i,
  input  logic                   end_window_i,
  output logic                   pct_valid_o,
  input  logic                   pct_ready_i,
  output logic [SENSORS*7-1:0]   pct_o
);
  import irdf_pkg::*;

  localparam int unsigned SW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};
  localparam int unsigned NW = COUNT_WIDTH + 7;
  localparam logic [1:0] StCount = 2'd0, StDiv = 2'd1, StOut = 2'd2;

  logic [COUNT_WIDTH-1:0] hits_q [SENSORS];
  logic [COUNT_WIDTH-1:0] hits_d [SENSORS];
  logic [COUNT_WIDTH-1:0] samp_q, samp_d;
  logic [1:0]             st_q, st_d;
  logic [SW-1:0]          sel_q, sel_d;
  logic [6:0]             bit_q, bit_d;   // quotient bit counter
  logic [NW-1:0]          num_q, num_d;
  logic [COUNT_WIDTH:0]   rem_q, rem_d;
  logic [6:0]             quo_q, quo_d;
  logic [6:0]             pct_q [SENSORS];
  logic                   accept;
  logic [COUNT_WIDTH+1:0] trial;

  assign in_ready = (st_q == StCount);
  assign accept   = in_valid && in_ready;
  assign pct_valid_o = (st_q == StOut);

  for (genvar g = 0; g < SENSORS; g++) begin : g_pct
    assign pct_o[g*7 +: 7] = pct_q[g];
  end

  // Restoring divide, one quotient bit a cycle; percentage fits 7 bits.
  assign trial = {rem_q, num_q[NW-1]} - {1'b0, 1'b0, samp_q};

  always_comb begin
    hits_d = hits_q;
    samp_d = samp_q;
    st_d   = st_q;
    sel_d  = sel_q;
    bit_d  = bit_q;
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    unique case (st_q)
      StCount: begin
        if (accept) begin
          for (int i = 0; i < SENSORS; i++) begin
            if (!sensor_levels_i[i] && hits_q[i] != CountMax) begin
              hits_d[i] = hits_q[i] + 1'b1;
            end
          end
          if (samp_q != CountMax) begin
            samp_d = samp_q + 1'b1;
          end
          if (end_window_i) begin
            st_d  = StDiv;
            sel_d = '0;
            bit_d = '0;
            rem_d = '0;
            quo_d = '0;
            num_d = NW'(hits_d[0]) * NW'(100);
          end
        end
      end
      StDiv: begin
        if (!trial[COUNT_WIDTH+1]) begin
          rem_d = trial[COUNT_WIDTH:0];
          quo_d = {quo_q[5:0], 1'b1};
        end else begin
          rem_d = {rem_q[COUNT_WIDTH-1:0], num_q[NW-1]};
          quo_d = {quo_q[5:0], 1'b0};
        end
        num_d = {num_q[NW-2:0], 1'b0};
        bit_d = bit_q + 1'b1;
        if (bit_q == 7'(NW - 1)) begin
          bit_d = '0;
          rem_d = '0;
          quo_d = '0;
          if (sel_q == SW'(SENSORS - 1)) begin
            st_d = StOut;
            for (int i = 0; i < SENSORS; i++) hits_d[i] = '0;
            samp_d = '0;
          end else begin
            sel_d = sel_q + 1'b1;
            num_d = NW'(hits_q[sel_q + 1'b1]) * NW'(100);
          end
        end
      end
      StOut: begin
        if (pct_ready_i) st_d = StCount;
      end
      default: st_d = StCount;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SENSORS; i++) hits_q[i] <= '0;
      samp_q <= '0;
      st_q   <= StCount;
      sel_q  <= '0;
      bit_q  <= '0;
    end else begin
      hits_q <= hits_d;
      samp_q <= samp_d;
      st_q   <= st_d;
      sel_q  <= sel_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (st_q == StDiv && bit_q == 7'(NW - 1)) begin
      if (!trial[COUNT_WIDTH+1]) pct_q[sel_q] <= 7'({quo_q[5:0], 1'b1} > 7'd100 ? 7'd100
                                                    : {quo_q[5:0], 1'b1});
      else pct_q[sel_q] <= 7'({quo_q[5:0], 1'b0} > 7'd100 ? 7'd100 : {quo_q[5:0], 1'b0});
    end
  end

endmodule

FILE: src/irdf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR ring direction finder queue
// Two-entry queue of percentage sets between front and back.
// ----------------------------------------------------------------------------
module irdf_queue #(
  parameter int unsigned WIDTH = 168
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

FILE: src/irdf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR ring direction finder back end
// Select strongest sensors, sum vector, run CORDIC angle.
// ----------------------------------------------------------------------------
module irdf_back #(
  parameter int unsigned SENSORS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [4:0]           top_count_i,
  input  logic                 pct_valid_i,
  output logic                 pct_ready_o,
  input  logic [SENSORS*7-1:0] pct_i,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [8:0]           direction_deg_o,
  output logic [6:0]           strength_pct_o
);
  import irdf_pkg::*;

  localparam int unsigned SW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int unsigned RW = $clog2(SENSORS + 1);
  localparam logic [2:0] StIdle = 3'd0, StScan = 3'd1, StPick = 3'd2,
                         StMul = 3'd3, StCord = 3'd4, StDeg = 3'd5, StOut = 3'd6;

  logic [2:0]        st_q;
  logic [6:0]        pct_q [SENSORS];
  logic [SENSORS-1:0] used_q;
  logic [SW-1:0]     idx_q;
  logic [RW-1:0]     rnd_q, limit_q;
  logic [6:0]        bv_q, strength_q;
  logic [SW-1:0]     best_q;
  logic              found_q;
  logic signed [24:0] px_q, py_q;
  logic signed [31:0] x_q, y_q;
  logic signed [31:0] z_q;
  logic [3:0]        it_q;
  logic [8:0]        deg_q;
  logic [5:0]        best_x;
  logic [4:0]        tab;
  logic signed [31:0] dx, dy, zabs;
  logic [31:0]       zdeg;

  assign pct_ready_o = (st_q == StIdle);
  assign out_valid   = (st_q == StOut);
  assign direction_deg_o = deg_q;
  assign strength_pct_o  = strength_q;
  // Fold the sensor index onto the table; one subtract covers up to 48 sensors.
  assign best_x = 6'(best_q);
  assign tab = (best_x >= 6'(TableSteps)) ? 5'(best_x - 6'(TableSteps)) : best_x[4:0];
  assign dx  = y_q >>> it_q;
  assign dy  = x_q >>> it_q;
  assign zabs = z_q[31] ? -z_q : z_q;
  assign zdeg = {16'd0, zabs[31:16]};

  // Truncating divide by 16384 toward zero.
  function automatic logic signed [15:0] q14(input logic signed [24:0] p);
    logic signed [24:0] a;
    a = p[24] ? (p + 25'sd16383) : p;
    return 16'(a >>> 14);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      unique case (st_q)
        StIdle: if (pct_valid_i) st_q <= StScan;
        StScan: if (idx_q == SW'(SENSORS - 1)) st_q <= StPick;
        StPick: begin
          if (!found_q || rnd_q >= limit_q) begin
            st_q <= (x_q == 0 && y_q == 0) ? StOut : StCord;
          end else begin
            st_q <= StMul;
          end
        end
        StMul:  st_q <= StScan;
        StCord: if (it_q == 4'(CordicSteps - 1)) st_q <= StDeg;
        StDeg:  st_q <= StOut;
        StOut:  if (out_ready) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        for (int i = 0; i < SENSORS; i++) pct_q[i] <= pct_i[i*7 +: 7];
        used_q  <= '0;
        idx_q   <= '0;
        rnd_q   <= '0;
        bv_q    <= '0;
        found_q <= 1'b0;
        strength_q <= '0;
        x_q <= '0;
        y_q <= '0;
        limit_q <= ({1'b0, top_count_i} > 6'(SENSORS)) ? RW'(SENSORS) : RW'(top_count_i);
        deg_q <= NoSignal;
      end
      StScan: begin
        if (!used_q[idx_q] && pct_q[idx_q] > bv_q) begin
          bv_q    <= pct_q[idx_q];
          best_q  <= idx_q;
          found_q <= 1'b1;
        end
        if (rnd_q == '0 && pct_q[idx_q] > strength_q) strength_q <= pct_q[idx_q];
        idx_q <= idx_q + 1'b1;
      end
      StPick: begin
        idx_q <= '0;
        if (found_q && rnd_q < limit_q) begin
          px_q <= 25'(cos_q14(tab)) * $signed({18'd0, bv_q});
          py_q <= 25'(cos_q14(sin_idx(tab))) * $signed({18'd0, bv_q});
          used_q[best_q] <= 1'b1;
        end else begin
          // Enter CORDIC: pre-rotate by 180 when x negative, scale by 2^16.
          it_q <= '0;
          if (x_q < 0) begin
            x_q <= (-x_q) <<< 16;
            y_q <= (-y_q) <<< 16;
            z_q <= 32'sd11796480;
          end else begin
            x_q <= x_q <<< 16;
            y_q <= y_q <<< 16;
            z_q <= '0;
          end
        end
      end
      StMul: begin
        x_q <= x_q + 32'(q14(px_q));
        y_q <= y_q + 32'(q14(py_q));
        rnd_q <= rnd_q + 1'b1;
        bv_q <= '0;
        found_q <= 1'b0;
      end
      StCord: begin
        if (y_q > 0) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + $signed({10'd0, atan_deg16(it_q)});
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - $signed({10'd0, atan_deg16(it_q)});
        end
        it_q <= it_q + 1'b1;
      end
      StDeg: begin
        // |z| stays below 360 degrees here, so one compare folds the range.
        if (!z_q[31]) begin
          deg_q <= (zdeg >= 32'd360) ? 9'(zdeg - 32'd360) : 9'(zdeg);
        end else if (zdeg == 32'd0) begin
          deg_q <= '0;
        end else begin
          deg_q <= 9'(32'd360 - zdeg);
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: src/ir_ring_direction_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR ring direction finder
// Counts IR hits per sensor over a window and reports direction and strength.
// ----------------------------------------------------------------------------
// Samples that do not close the window are taken one per cycle while the
// front is counting. A closing sample starts a restoring division per sensor
// in the front, then the back runs selection and 16 CORDIC iterations before
// the result beat. The two-entry queue lets the front count the next window
// meanwhile. Reset clears the hit and sample counters, sets top_count to 6;
// no clearing pass.
module ir_ring_direction_finder #(
  parameter int unsigned SENSORS     = 24,
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SENSORS-1:0] sensor_levels_i,
  input  logic               end_window_i,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [8:0]         direction_deg_o,
  output logic [6:0]         strength_pct_o
);
  import irdf_pkg::*;

  localparam int unsigned PW = SENSORS * 7;

  logic [4:0]    top_q;
  logic          f_valid, f_ready, b_valid, b_ready;
  logic [PW-1:0] f_data, b_data;

  // Configuration is always accepted; hold it in one register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= TopReset;
    end else if (cfg_valid) begin
      top_q <= cfg_data;
    end
  end

  irdf_front #(.SENSORS(SENSORS), .COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .sensor_levels_i, .end_window_i,
    .pct_valid_o(f_valid), .pct_ready_i(f_ready), .pct_o(f_data)
  );

  irdf_queue #(.WIDTH(PW)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_data),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_data)
  );

  irdf_back #(.SENSORS(SENSORS)) u_back (
    .clk_i, .rst_ni, .top_count_i(top_q),
    .pct_valid_i(b_valid), .pct_ready_o(b_ready), .pct_i(b_data),
    .out_valid, .out_ready, .direction_deg_o, .strength_pct_o
  );

endmodule

FILE: src/irdf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR ring direction finder checker
// Port-level properties of the result channel.
// ----------------------------------------------------------------------------
module irdf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [8:0] direction_deg_o,
  input logic [6:0] strength_pct_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(direction_deg_o))
    else $error("result dropped");
  a_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> direction_deg_o < 9'd360 || direction_deg_o == 9'd400)
    else $error("bad direction");
  a_str: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> strength_pct_o <= 7'd100)
    else $error("bad strength");
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && strength_pct_o == 7'd0 |-> direction_deg_o == 9'd400)
    else $error("no signal yet direction given");
endmodule

bind ir_ring_direction_finder irdf_checker u_chk (
  .clk_i, .rst_ni, .out_valid, .out_ready, .direction_deg_o, .strength_pct_o
);

FILE: dv/tb_ir_ring_direction_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR ring direction finder testbench
// Drives sensor samples and window closes through the valid/ready channels.
// A local model predicts direction and strength of each closed window, and a
// checker compares every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_ir_ring_direction_finder;
  import irdf_pkg::*;

  localparam int unsigned NSens    = 24;
  localparam int unsigned CntMax   = 1023;
  localparam int unsigned WinSlack = NSens * 17 + 24 * 26 + NSens + 40;
  localparam longint unsigned CycleLimit = 64'd3_000_000;

  typedef struct packed {
    logic [8:0] direction;
    logic [6:0] strength;
  } bearing_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [4:0]       cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic [NSens-1:0] sensor_levels_i;
  logic             end_window_i;
  logic             out_valid;
  logic             out_ready;
  logic [8:0]       direction_deg_o;
  logic [6:0]       strength_pct_o;

  // Shadow state of the block.
  int unsigned hits_q [NSens];
  int unsigned samples_q;
  int unsigned top_q;

  bearing_t    bearing_queue[$];
  int unsigned fail_count;
  longint unsigned cycle_count;
  bit          quiet_mode;   // no idling on either side when set

  ir_ring_direction_finder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sensor_levels_i (sensor_levels_i),
    .end_window_i    (end_window_i),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .direction_deg_o (direction_deg_o),
    .strength_pct_o  (strength_pct_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("ir_ring_direction_finder verification failed");
      $finish;
    end
  end

  // Vectoring CORDIC on the summed vector; angle in 2^-16 degree units, returned in whole degrees.
  function automatic int unsigned cordic_bearing(longint signed vx, longint signed vy);
    longint signed x, y, z, dx, dy, deg;
    x = vx;
    y = vy;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 64'sd180 * 65536;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;   // arithmetic shift floors
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(atan_deg16(4'(i)));
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(atan_deg16(4'(i)));
      end
    end
    deg = (z >= 0) ? (z / 65536) : -((-z) / 65536);
    deg = deg % 360;
    if (deg < 0) begin
      deg = deg + 360;
    end
    return int'(deg);
  endfunction

  // Count one sample; on a window close compute the bearing and clear counters.
  function automatic void account_sample(logic [NSens-1:0] levels, logic close);
    int unsigned pct [NSens];
    bit          taken [NSens];
    int unsigned peak, limit, bv;
    int          best;
    longint signed sx, sy, cv, sv;
    bearing_t    b;
    for (int i = 0; i < NSens; i++) begin
      if (!levels[i] && hits_q[i] < CntMax) begin
        hits_q[i]++;
      end
    end
    if (samples_q < CntMax) begin
      samples_q++;
    end
    if (!close) begin
      return;
    end
    peak = 0;
    for (int i = 0; i < NSens; i++) begin
      pct[i] = (samples_q != 0) ? (100 * hits_q[i]) / samples_q : 0;
      if (pct[i] > 100) begin
        pct[i] = 100;
      end
      taken[i] = 1'b0;
      if (pct[i] > peak) begin
        peak = pct[i];
      end
      hits_q[i] = 0;
    end
    samples_q = 0;
    sx = 0;
    sy = 0;
    limit = (top_q > NSens) ? NSens : top_q;
    for (int r = 0; r < limit; r++) begin
      best = -1;
      bv = 0;
      for (int i = 0; i < NSens; i++) begin
        if (!taken[i] && pct[i] > bv) begin
          bv = pct[i];
          best = i;
        end
      end
      if (best < 0) begin
        break;
      end
      taken[best] = 1'b1;
      cv = longint'(cos_q14(5'(best % TableSteps)));
      sv = longint'(cos_q14(sin_idx(5'(best % TableSteps))));
      // SV division truncates toward zero, as required per term
      sx = sx + (cv * longint'(bv)) / 16384;
      sy = sy + (sv * longint'(bv)) / 16384;
    end
    b.direction = (sx == 0 && sy == 0) ? NoSignal : 9'(cordic_bearing(sx, sy));
    b.strength  = 7'(peak);
    bearing_queue.push_back(b);
  endfunction

  // Send one sample beat with optional random gap ahead of it.
  // Valid stays high after the accept edge until the next gap or pause drops it.
  task automatic send_sample(logic [NSens-1:0] levels, logic close);
    if (!quiet_mode) begin
      while ($urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid        <= 1'b1;
    sensor_levels_i <= levels;
    end_window_i    <= close;
    do @(posedge clk_i); while (!in_ready);
    account_sample(levels, close);
  endtask

  // Write top_count only once the block has drained.
  task automatic write_top(logic [4:0] value);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    top_q = value;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (bearing_queue.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (WinSlack) @(posedge clk_i);
  endtask

  // Result side: random back-pressure outside quiet mode, compare each beat.
  always @(posedge clk_i or negedge rst_ni) begin
    bearing_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (bearing_queue.size() == 0) begin
          $error("result beat with nothing expected: dir=%0d str=%0d",
                 direction_deg_o, strength_pct_o);
          fail_count++;
        end else begin
          want = bearing_queue.pop_front();
          if (direction_deg_o !== want.direction) begin
            $error("direction_deg exp=%0d act=%0d", want.direction, direction_deg_o);
            fail_count++;
          end
          if (strength_pct_o !== want.strength) begin
            $error("strength_pct exp=%0d act=%0d", want.strength, strength_pct_o);
            fail_count++;
          end
        end
      end
      out_ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 29);
    end
  end

  // Window of n samples; each sensor hit with its own probability (percent).
  task automatic send_window(int unsigned n, int unsigned prob [NSens]);
    logic [NSens-1:0] lv;
    for (int unsigned k = 0; k < n; k++) begin
      for (int i = 0; i < NSens; i++) begin
        lv[i] = !($urandom_range(99) < prob[i]);
      end
      send_sample(lv, k == n - 1);
    end
  endtask

  task automatic test_directed();
    send_sample('1, 1'b1);                 // no signal at all
    send_sample('0, 1'b1);                 // every sensor full
    send_sample(24'hFFFFFE, 1'b1);         // one sensor only
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'hFFFFFF, 1'b1);         // sensor 23 at 66 percent
    send_sample(24'hAAAAAA, 1'b0);
    send_sample(24'h555555, 1'b1);         // ties across all sensors
    send_sample(24'hFFF000, 1'b0);
    send_sample(24'hF0F0F0, 1'b0);
    send_sample(24'h0F0F0F, 1'b1);
    send_sample(24'hFFEFFF, 1'b1);         // opposite side, negative x
    send_sample(24'hFFFBFF, 1'b1);
    send_sample(24'hFFDFF7, 1'b1);         // two sensors, 3 and 13
  endtask

  // Long window drives the sample counter and the counters of sensors 16 to 23 into saturation.
  task automatic test_saturation();
    for (int k = 0; k < 1100; k++) begin
      send_sample((k % 3 == 0) ? 24'h000000 : 24'h00FFFF, k == 1099);
    end
  endtask

  task automatic test_top_count();
    logic [4:0] sweep [6] = '{5'd0, 5'd1, 5'd24, 5'd31, 5'd13, TopReset};
    int unsigned prob [NSens];
    foreach (sweep[s]) begin
      write_top(sweep[s]);
      for (int w = 0; w < 3; w++) begin
        foreach (prob[i]) prob[i] = $urandom_range(100);
        send_window($urandom_range(1, 12), prob);
      end
    end
  endtask

  task automatic test_random();
    int unsigned prob [NSens];
    int unsigned centre;
    int unsigned win;
    win = 0;
    while (win < 36) begin
      quiet_mode = (win >= 12 && win < 22);
      centre = $urandom_range(NSens - 1);
      foreach (prob[i]) begin
        // mostly a lobe around one sensor, sometimes pure noise
        if ($urandom_range(3) == 0) begin
          prob[i] = $urandom_range(100);
        end else begin
          prob[i] = (i == centre || i == (centre + 1) % NSens) ? $urandom_range(60, 100)
                                                             : $urandom_range(10);
        end
      end
      send_window($urandom_range(1, 20), prob);
      win++;
      if (win == 22) begin
        wait_drain();       // hold sender until all results have come
        write_top(5'($urandom_range(1, 24)));
      end
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    sensor_levels_i = '1;
    end_window_i    = 1'b0;
    fail_count      = 0;
    cycle_count     = 0;
    quiet_mode      = 1'b0;
    top_q           = TopReset;
    samples_q       = 0;
    foreach (hits_q[i]) hits_q[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_saturation();
    test_top_count();
    test_random();

    wait_drain();
    if (fail_count == 0) begin
      $display("ir_ring_direction_finder verification clean");
    end else begin
      $display("ir_ring_direction_finder verification failed");
    end
    $finish;
  end

endmodule
